[hw/rtl/lfpid_pkg.sv]
package lfpid_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [12:0] POS_MAX = 13'd7000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_SPEED_LIMIT   = 3'd3,
    REG_STOP_ON_WHITE = 3'd4,
    REG_LOW_LEVEL     = 3'd5,
    REG_HIGH_LEVEL    = 3'd6,
    REG_STOP_HOLD_MS  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] line_pos;
    logic [11:0] sensor_0;
    logic [11:0] sensor_1;
    logic [11:0] sensor_2;
    logic [11:0] sensor_3;
    logic [11:0] sensor_4;
    logic [11:0] sensor_5;
    logic [11:0] sensor_6;
    logic [11:0] sensor_7;
    logic [31:0] now_ms;
    logic        abort_req;
    logic        new_run;
  } in_t;

  typedef struct packed {
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       drive_on;
    logic       stop_seen;
  } out_t;

endpackage

[hw/rtl/line_follow_pid_with_stop_timer_unit.sv]
// PID line follower for a differential drive with a stop timer. One control tick
// per transfer on the input channel, one result per tick on the output channel.
// A tick sits in the input register while the stop test, the integral and
// stop-latch update, the three gain products and the clamps are worked out, and
// its result is loaded into the output register, raising out_valid_o, at the
// first edge at which that register is free. A new tick can be taken every
// cycle while the output is not stalled; the state update completes in the
// cycle the tick leaves the input register, so the next tick always sees it.
// The input stalls only while both registers are full and the output is stalled.
// Registers: 0 gain_p, 1 gain_i, 2 gain_d (unsigned Q4.12), 3 speed_limit,
// 4 stop_on_white, 5 low_level, 6 high_level, 7 stop_hold_ms. Write them only
// while no tick is in flight. Once stopped (hold time elapsed or abort), PWM is 0,
// drive_on is 0 and the PID state is frozen until a tick with new_run set.
module line_follow_pid_with_stop_timer_unit #(
  parameter int unsigned BASE_SPEED     = 50,
  parameter int unsigned LINE_CENTER    = 3500,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lfpid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfpid_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lfpid_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lfpid_pkg::out_t                      out_data_o
);
  import lfpid_pkg::*;

  localparam logic signed [51:0] BASE_S = 52'(BASE_SPEED);
  localparam logic signed [51:0] RND    = (52'sd1 <<< GAIN_FRAC_BITS) - 52'sd1;
  localparam logic signed [13:0] CTR_S  = 14'(LINE_CENTER);

  // configuration
  logic [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic [7:0]  speed_limit_q;
  logic        stop_on_white_q;
  logic [11:0] low_level_q, high_level_q;
  logic [10:0] stop_hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q        <= 16'd205;
      gain_i_q        <= 16'd0;
      gain_d_q        <= 16'd2048;
      speed_limit_q   <= 8'd255;
      stop_on_white_q <= 1'b0;
      low_level_q     <= 12'd0;
      high_level_q    <= 12'd4095;
      stop_hold_ms_q  <= 11'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:        gain_p_q        <= cfg_wdata_i;
        REG_GAIN_I:        gain_i_q        <= cfg_wdata_i;
        REG_GAIN_D:        gain_d_q        <= cfg_wdata_i;
        REG_SPEED_LIMIT:   speed_limit_q   <= cfg_wdata_i[7:0];
        REG_STOP_ON_WHITE: stop_on_white_q <= cfg_wdata_i[0];
        REG_LOW_LEVEL:     low_level_q     <= cfg_wdata_i[11:0];
        REG_HIGH_LEVEL:    high_level_q    <= cfg_wdata_i[11:0];
        REG_STOP_HOLD_MS:  stop_hold_ms_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // handshake: each register loads when empty or when it moves on
  logic v1_q, vo_q;
  logic rdy1, rdyo;

  assign rdyo = !vo_q || !out_stall_i;
  assign rdy1 = !v1_q || rdyo;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdyo) vo_q <= v1_q;
    end
  end

  // input register
  in_t in_q;
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) in_q <= in_data_i;
  end

  // stop test, state update
  logic               fire;
  logic               seen_c;
  logic [12:0]        pos_sat;
  logic signed [13:0] err_c;
  logic signed [14:0] deriv_c;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_c;
  logic [31:0]        elapsed;
  logic               white_ok, black_ok;

  logic signed [31:0] err_sum_q, err_sum_d;
  logic signed [13:0] prev_err_q, prev_err_d;
  logic               armed_q, armed_d;
  logic [31:0]        t_start_q, t_start_d;
  logic               stopped_q, stopped_d;
  logic               run_c;

  assign fire = v1_q && rdyo;

  always_comb begin
    white_ok = (in_q.sensor_0 <= low_level_q) && (in_q.sensor_1 <= low_level_q) &&
               (in_q.sensor_2 <= low_level_q) && (in_q.sensor_3 <= low_level_q) &&
               (in_q.sensor_4 <= low_level_q) && (in_q.sensor_5 <= low_level_q) &&
               (in_q.sensor_6 <= low_level_q) && (in_q.sensor_7 <= low_level_q);
    black_ok = (in_q.sensor_0 >= high_level_q) && (in_q.sensor_1 >= high_level_q) &&
               (in_q.sensor_2 >= high_level_q) && (in_q.sensor_3 >= high_level_q) &&
               (in_q.sensor_4 >= high_level_q) && (in_q.sensor_5 >= high_level_q) &&
               (in_q.sensor_6 >= high_level_q) && (in_q.sensor_7 >= high_level_q);
    seen_c = stop_on_white_q ? white_ok : black_ok;

    pos_sat  = (in_q.line_pos > POS_MAX) ? POS_MAX : in_q.line_pos;
    err_c    = CTR_S - $signed({1'b0, pos_sat});
    deriv_c  = 15'(err_c) - 15'(prev_err_q);
    sum_wide = 33'(err_sum_q) + 33'(err_c);
    if (sum_wide[32] != sum_wide[31]) begin
      // saturate toward the sign of the true sum
      sum_c = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_c = sum_wide[31:0];
    end
    elapsed = in_q.now_ms - t_start_q;

    err_sum_d  = err_sum_q;
    prev_err_d = prev_err_q;
    t_start_d  = t_start_q;
    armed_d    = in_q.new_run ? 1'b0 : armed_q;
    stopped_d  = in_q.new_run ? 1'b0 : stopped_q;
    run_c      = !stopped_d;

    if (run_c) begin
      err_sum_d  = sum_c;
      prev_err_d = err_c;
      if (seen_c) begin
        if (!armed_d) begin
          armed_d   = 1'b1;
          t_start_d = in_q.now_ms;
        end else if (elapsed > {21'd0, stop_hold_ms_q}) begin
          stopped_d = 1'b1;
        end
      end else begin
        armed_d = 1'b0;
      end
      if (in_q.abort_req) stopped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      prev_err_q <= '0;
      armed_q    <= 1'b0;
      t_start_q  <= '0;
      stopped_q  <= 1'b0;
    end else if (fire) begin
      err_sum_q  <= err_sum_d;
      prev_err_q <= prev_err_d;
      armed_q    <= armed_d;
      t_start_q  <= t_start_d;
      stopped_q  <= stopped_d;
    end
  end

  function automatic logic [7:0] clamp_pwm(input logic signed [51:0] v,
                                           input logic [7:0] lim);
    logic [7:0] r;
    if (v[51]) begin
      r = 8'd0;
    end else if (v > $signed({44'd0, lim})) begin
      r = lim;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // gain products, scale toward zero, mix, clamp
  logic signed [30:0] prod_p;
  logic signed [48:0] prod_i;
  logic signed [31:0] prod_d;
  logic signed [50:0] acc_c;
  logic signed [51:0] acc_rnd, corr;
  out_t               res_c;

  always_comb begin
    prod_p  = $signed({1'b0, gain_p_q}) * err_c;
    prod_i  = $signed({1'b0, gain_i_q}) * sum_c;
    prod_d  = $signed({1'b0, gain_d_q}) * deriv_c;
    acc_c   = 51'(prod_p) + 51'(prod_i) + 51'(prod_d);
    acc_rnd = 52'(acc_c) + (acc_c[50] ? RND : 52'sd0);
    corr    = acc_rnd >>> GAIN_FRAC_BITS;
    res_c.duty_left  = run_c ? clamp_pwm(BASE_S + corr, speed_limit_q) : 8'd0;
    res_c.duty_right = run_c ? clamp_pwm(BASE_S - corr, speed_limit_q) : 8'd0;
    res_c.drive_on   = run_c;
    res_c.stop_seen  = seen_c;
  end

  out_t out_q;
  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res_c;
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/lfpid_checker.sv]
module lfpid_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input lfpid_pkg::out_t out_data_o
);
  import lfpid_pkg::*;

  // a stopped tick never drives the motors
  a_stopped_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.drive_on |->
      out_data_o.duty_left == 8'd0 && out_data_o.duty_right == 8'd0)
    else $error("PWM nonzero on a stopped tick");

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // a result out of an empty output register comes from an input transfer that passed through the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind line_follow_pid_with_stop_timer_unit lfpid_checker u_lfpid_checker (.*);
